[design/sshfd_pkg.sv]
// Shared types, frame constants and segment decode function for the height frame decoder.
package sshfd_pkg;

	localparam logic [7:0] HDR_BYTE  = 8'h9b;
	localparam logic [7:0] LEN_BYTE  = 8'h07;
	localparam logic [7:0] TYPE_BYTE = 8'h12;
	localparam logic [7:0] END_BYTE  = 8'h9d;
	localparam logic [7:0] DP_BIT    = 8'h80;

	localparam logic [3:0] NO_DIGIT  = 4'd10;
	localparam logic [3:0] TENS_MIN  = 4'd2;
	localparam logic [3:0] TENS_MAX  = 4'd4;

	localparam int unsigned HEIGHT_W = 9;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'd0,
		PH_LENGTH = 4'd1,
		PH_TYPE   = 4'd2,
		PH_TENS   = 4'd3,
		PH_ONES   = 4'd4,
		PH_TENTHS = 4'd5,
		PH_CK1    = 4'd6,
		PH_CK2    = 4'd7,
		PH_END    = 4'd8
	} phase_t;

	// Result of one step of the frame tracker
	typedef struct packed {
		logic                emit;
		logic [HEIGHT_W-1:0] height;
	} step_res_t;

	// Map a seven-segment code to its digit, NO_DIGIT when it is not a digit
	function automatic logic [3:0] seg_to_digit(input logic [7:0] code);
		logic [3:0] d;
		unique case (code)
			8'h3f:   d = 4'd0;
			8'h06:   d = 4'd1;
			8'h5b:   d = 4'd2;
			8'h4f:   d = 4'd3;
			8'h66:   d = 4'd4;
			8'h6d:   d = 4'd5;
			8'h7c:   d = 4'd6;
			8'h07:   d = 4'd7;
			8'h7f:   d = 4'd8;
			8'h6f:   d = 4'd9;
			default: d = NO_DIGIT;
		endcase
		return d;
	endfunction

endpackage

[design/sshfd_frame_fsm.sv]
// Frame position tracker: header hunt, digit capture and height assembly.
module sshfd_frame_fsm (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output sshfd_pkg::step_res_t  res
);
	import sshfd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [2:0]  tens_q, tens_d;
	logic [3:0]  ones_q, ones_d;
	logic [3:0]  tenths_q, tenths_d;
	logic [3:0]  dig_plain;
	logic [3:0]  dig_dp;
	logic [HEIGHT_W-1:0] height;

	// Decode the byte both as a plain digit and with the decimal point removed
	assign dig_plain = seg_to_digit(rx_byte);
	assign dig_dp    = seg_to_digit(rx_byte ^ DP_BIT);

	// Next phase and digit captures
	always_comb begin
		phase_d  = phase_q;
		tens_d   = tens_q;
		ones_d   = ones_q;
		tenths_d = tenths_q;
		unique case (phase_q)
			PH_LENGTH: phase_d = (rx_byte == LEN_BYTE) ? PH_TYPE : PH_HUNT;
			PH_TYPE:   phase_d = (rx_byte == TYPE_BYTE) ? PH_TENS : PH_HUNT;
			PH_TENS: begin
				if (dig_plain >= TENS_MIN && dig_plain <= TENS_MAX) begin
					tens_d  = dig_plain[2:0];
					phase_d = PH_ONES;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_ONES: begin
				if (dig_dp != NO_DIGIT) begin
					ones_d  = dig_dp;
					phase_d = PH_TENTHS;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_TENTHS: begin
				if (dig_plain != NO_DIGIT) begin
					tenths_d = dig_plain;
					phase_d  = PH_CK1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_CK1:  phase_d = PH_CK2;
			PH_CK2:  phase_d = PH_END;
			PH_END:  phase_d = PH_HUNT;
			default: phase_d = (rx_byte == HDR_BYTE) ? PH_LENGTH : PH_HUNT;
		endcase
	end

	// Assemble the height from the captured digits
	assign height = HEIGHT_W'(tens_q) * HEIGHT_W'(100)
	              + HEIGHT_W'(ones_q) * HEIGHT_W'(10)
	              + HEIGHT_W'(tenths_q);

	// Emit on a correct end byte
	always_comb begin
		res.emit   = 1'b0;
		res.height = height;
		if (phase_q == PH_END && rx_byte == END_BYTE) begin
			res.emit = 1'b1;
		end
	end

	// Advance state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			tens_q   <= '0;
			ones_q   <= '0;
			tenths_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			tens_q   <= tens_d;
			ones_q   <= ones_d;
			tenths_q <= tenths_d;
		end
	end

	// Tens digit is within two to four once past the tens byte
	a_tens_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ONES || phase_q == PH_TENTHS || phase_q == PH_CK1 ||
		 phase_q == PH_CK2 || phase_q == PH_END)
		|-> (tens_q >= 3'd2 && tens_q <= 3'd4))
		else $error("tens digit out of range in frame body");

endmodule

[design/seven_segment_height_frame_decoder.sv]
// Top level of the seven-segment height frame decoder.
// Usage:
//   Input channel rx_valid / rx_stall / rx_byte carries one serial byte per
//   transfer. The decoder hunts for header 0x9b, length 0x07, type 0x12,
//   then three seven-segment digit bytes, two unchecked checksum bytes and
//   end byte 0x9d. A complete frame yields one transfer on the output
//   channel height_valid / height_stall / height_tenths (200..499).
//   A byte that breaks the frame sends the decoder back to hunting.
// Result path: the end byte is first held in the input register, then the
//   result register loads from the frame tracker's emit, unless a result
//   still waits in the output register.
// Throughput: one byte per cycle while rx_stall is low; the frame tracker steps once per byte.
// Stall: while a result waits in the output register, bytes that give no
//   result keep flowing; only an end byte that completes a frame holds in
//   the input register, which raises rx_stall.
// Reset: arst_n clears the valid flags of both registers and returns the tracker to hunting.
module seven_segment_height_frame_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_stall,
	input  logic [7:0] rx_byte,
	output logic       height_valid,
	input  logic       height_stall,
	output logic [8:0] height_tenths
);
	import sshfd_pkg::*;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                out_valid_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                out_free;
	logic                step;
	step_res_t           res;

	// Frame tracker processes the held byte
	sshfd_frame_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.res     (res)
	);

	// Advance the held byte unless its result cannot enter the output register
	assign out_free = !out_valid_q || !height_stall;
	assign step     = valid_s1 && (!res.emit || out_free);
	assign rx_stall = valid_s1 && !step;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!rx_stall && rx_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Result register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res.emit) begin
			out_valid_q <= 1'b1;
		end else if (!height_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.emit) begin
			height_q <= res.height;
		end
	end

	assign height_valid  = out_valid_q;
	assign height_tenths = height_q;

	// Stall is raised only for a held byte
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// A blocked byte stays put for the next cycle
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |=> (valid_s1 && $stable(byte_s1)))
		else $error("blocked byte lost from input register");

	// Results are always a legal height
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		height_valid |-> (height_tenths >= 9'd200 && height_tenths <= 9'd499))
		else $error("height result out of range");

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(height_valid && height_stall) |-> !(step && res.emit))
		else $error("waiting result overwritten");

endmodule

[dv/tb_seven_segment_height_frame_decoder.sv]
// Testbench for the seven-segment height frame decoder: frame tracking predictor and result checker.
`timescale 1ns / 1ps

module tb_seven_segment_height_frame_decoder;

	import sshfd_pkg::*;

	// Segment patterns for digits 0..9
	localparam logic [7:0] SEG_CODE [10] = '{
		8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7c, 8'h07, 8'h7f, 8'h6f
	};
	localparam int FLUSH_CYCLES = 10;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_stall;
	logic [7:0] rx_byte = 8'h00;
	logic       height_valid;
	logic       height_stall = 1'b0;
	logic [8:0] height_tenths;

	// Predictor state
	phase_t     trk_phase = PH_HUNT;
	logic [2:0] trk_tens = '0;
	logic [3:0] trk_ones = '0;
	logic [3:0] trk_tenths = '0;

	logic [8:0] expected_heights [$];
	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int bytes_sent = 0;
	int heights_checked = 0;

	seven_segment_height_frame_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_stall     (rx_stall),
		.rx_byte      (rx_byte),
		.height_valid (height_valid),
		.height_stall (height_stall),
		.height_tenths(height_tenths)
	);

	always #5 clk = ~clk;

	// Hard stop in case the flow locks up
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Look up the digit of a segment pattern, NO_DIGIT when unknown
	function automatic logic [3:0] digit_of_code(input logic [7:0] code);
		logic [3:0] d;
		d = NO_DIGIT;
		for (int i = 0; i < 10; i++) begin
			if (SEG_CODE[i] == code)
				d = 4'(i);
		end
		return d;
	endfunction

	// Step the frame tracker by one byte; return 1 when a height completes
	function automatic bit advance_tracker(input logic [7:0] b, output logic [8:0] h);
		logic [3:0] d;
		bit done;
		done = 1'b0;
		h = '0;
		case (trk_phase)
			PH_LENGTH: trk_phase = (b == LEN_BYTE) ? PH_TYPE : PH_HUNT;
			PH_TYPE:   trk_phase = (b == TYPE_BYTE) ? PH_TENS : PH_HUNT;
			PH_TENS: begin
				d = digit_of_code(b);
				if (d >= TENS_MIN && d <= TENS_MAX) begin
					trk_tens = d[2:0];
					trk_phase = PH_ONES;
				end else begin
					trk_phase = PH_HUNT;
				end
			end
			PH_ONES: begin
				d = digit_of_code(b ^ DP_BIT);
				if (d != NO_DIGIT) begin
					trk_ones = d;
					trk_phase = PH_TENTHS;
				end else begin
					trk_phase = PH_HUNT;
				end
			end
			PH_TENTHS: begin
				d = digit_of_code(b);
				if (d != NO_DIGIT) begin
					trk_tenths = d;
					trk_phase = PH_CK1;
				end else begin
					trk_phase = PH_HUNT;
				end
			end
			PH_CK1: trk_phase = PH_CK2;
			PH_CK2: trk_phase = PH_END;
			PH_END: begin
				trk_phase = PH_HUNT;
				if (b == END_BYTE) begin
					h = 9'(int'(trk_tens) * 100 + int'(trk_ones) * 10 + int'(trk_tenths));
					done = 1'b1;
				end
			end
			default: trk_phase = (b == HDR_BYTE) ? PH_LENGTH : PH_HUNT;
		endcase
		return done;
	endfunction

	// Present one byte, hold it until the transfer, then predict
	task automatic send_byte(input logic [7:0] b);
		logic [8:0] h;
		while ($urandom_range(99) < idle_pct) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (rx_stall);
		bytes_sent++;
		if (advance_tracker(b, h))
			expected_heights.push_back(h);
	endtask

	// Send a full frame for the given digits and checksum bytes
	task automatic send_frame(input int tens, input int ones, input int tenths,
			input logic [7:0] ck1, input logic [7:0] ck2);
		send_byte(HDR_BYTE);
		send_byte(LEN_BYTE);
		send_byte(TYPE_BYTE);
		send_byte(SEG_CODE[tens]);
		send_byte(SEG_CODE[ones] ^ DP_BIT);
		send_byte(SEG_CODE[tenths]);
		send_byte(ck1);
		send_byte(ck2);
		send_byte(END_BYTE);
	endtask

	// Hold the sender until every pending height has been seen
	task automatic drain_heights();
		rx_valid <= 1'b0;
		@(posedge clk);
		while (expected_heights.size() != 0)
			@(posedge clk);
	endtask

	// Lowest and highest heights; the first frame has checksums that look like header and end
	task automatic test_extreme_heights();
		send_frame(2, 0, 0, HDR_BYTE, END_BYTE);
		send_frame(4, 9, 9, 8'hff, 8'h00);
	endtask

	// Repeated header, tens digit out of range, wrong end byte
	task automatic test_broken_frames();
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(LEN_BYTE);
		send_byte(HDR_BYTE);
		send_byte(LEN_BYTE);
		send_byte(TYPE_BYTE);
		send_byte(SEG_CODE[1]);
		send_byte(HDR_BYTE);
		send_byte(LEN_BYTE);
		send_byte(TYPE_BYTE);
		send_byte(SEG_CODE[3]);
		send_byte(SEG_CODE[5] ^ DP_BIT);
		send_byte(SEG_CODE[7]);
		send_byte(8'h12);
		send_byte(8'h34);
		send_byte(8'h9c);
	endtask

	// Mostly well-formed frames with random digits, plus noise and damaged frames
	task automatic test_random_frames(input int idle, input int stall, input int n_bytes);
		logic [7:0] frame [9];
		int stop;
		int kind;
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			// Drop a few noise bytes between frames
			if ($urandom_range(2) == 0) begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom_range(255)));
			end
			frame[0] = HDR_BYTE;
			frame[1] = LEN_BYTE;
			frame[2] = TYPE_BYTE;
			frame[3] = SEG_CODE[$urandom_range(2, 4)];
			frame[4] = SEG_CODE[$urandom_range(9)] ^ DP_BIT;
			frame[5] = SEG_CODE[$urandom_range(9)];
			frame[6] = 8'($urandom_range(255));
			frame[7] = 8'($urandom_range(255));
			frame[8] = END_BYTE;
			stop = 9;
			kind = $urandom_range(99);
			if (kind >= 70 && kind < 80)
				frame[$urandom_range(8)] = 8'($urandom_range(255));
			else if (kind >= 80 && kind < 85)
				frame[3] = SEG_CODE[$urandom_range(9)];
			else if (kind >= 85 && kind < 90)
				frame[4] = SEG_CODE[$urandom_range(9)];
			else if (kind >= 90)
				stop = $urandom_range(1, 8);
			for (int i = 0; i < stop; i++)
				send_byte(frame[i]);
		end
		drain_heights();
	endtask

	// Randomly stall the result channel
	always @(posedge clk)
		height_stall <= ($urandom_range(99) < stall_pct);

	// Compare each result transfer with the oldest predicted height
	always @(posedge clk) begin
		logic [8:0] want;
		if (arst_n && height_valid && !height_stall) begin
			if (expected_heights.size() == 0) begin
				$error("height_tenths: unexpected result, actual %0d", height_tenths);
				errors++;
			end else begin
				want = expected_heights.pop_front();
				if (height_tenths !== want) begin
					$error("height_tenths: expected %0d, actual %0d", want, height_tenths);
					errors++;
				end
				heights_checked++;
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extreme_heights();
		test_broken_frames();
		drain_heights();

		test_random_frames(0, 0, 490);
		test_random_frames(86, 0, 490);
		test_random_frames(0, 86, 490);
		test_random_frames(25, 25, 490);

		// Let any late result surface before judging
		repeat (FLUSH_CYCLES) @(posedge clk);

		$display("Sent %0d bytes of frames, noise and damaged frames; checked %0d heights",
			bytes_sent, heights_checked);
		$display("under free flow, sparse input, heavy output stall and mixed stalls.");
		if (errors == 0 && expected_heights.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
design/sshfd_pkg.sv
design/sshfd_frame_fsm.sv
design/seven_segment_height_frame_decoder.sv
dv/tb_seven_segment_height_frame_decoder.sv
